// ===== sv/crtc_pkg.sv =====
// Shared types and constants for the CRT controller register and timing block.
`timescale 1ns / 1ps
`default_nettype none
package crtc_pkg;

  // Item kinds carried on the input channel
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_FRAME = 2'd2,
    MODE_LINE  = 2'd3
  } crtc_mode_t;

  localparam int LINE_W  = 13;
  localparam int HTOT_W  = 9;
  localparam int REG_NUM = 18;
  localparam int IDX_W   = 5;

  // Register indexes
  localparam int REG_HTOTAL  = 0;
  localparam int REG_HDISP   = 1;
  localparam int REG_HSYNC   = 2;
  localparam int REG_SYNCW   = 3;
  localparam int REG_VTOTAL  = 4;
  localparam int REG_VADJ    = 5;
  localparam int REG_VDISP   = 6;
  localparam int REG_VSYNC   = 7;
  localparam int REG_MODE    = 8;
  localparam int REG_MAXSCAN = 9;
  localparam int REG_DIRTY_LIM = 10;
  localparam int REG_READ_LO = 12;

  // Reset timing constants
  localparam int CHARS_MIN      = 54;
  localparam int HDISP_WIDE     = 80;
  localparam int HDISP_NARROW   = 40;
  localparam int HSYNC_RST_GAP  = 4;
  localparam int VSYNC_RST_GAP  = 16;

  localparam logic [7:0] RDATA_NONE        = 8'hFF;
  localparam logic [1:0] DISPLAY_OFF       = 2'b11;
  localparam logic [4:0] VSYNC_WIDTH_FULL  = 5'd16;

  // Register contents and control handed from the register file to the timing unit
  typedef struct packed {
    logic [7:0] htot_m1;
    logic [7:0] hdisp;
    logic [7:0] hsync;
    logic [7:0] sync_width;
    logic [7:0] vtot_rows;
    logic [7:0] vdisp_rows;
    logic [7:0] vsync_row;
    logic [7:0] mode_ctl;
    logic [7:0] max_scan;
    logic [7:0] scan_shadow;
    logic [7:0] height_shadow;
    logic       dirty;
    logic       recompute_go;
  } crtc_setup_t;

endpackage
`default_nettype wire

// ===== sv/crtc_regs.sv =====
// Register file: index port, data registers, shadow copies and change tracking.
`timescale 1ns / 1ps
`default_nettype none
module crtc_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire crtc_pkg::crtc_mode_t mode,
  input  wire logic               addr_bit,
  input  wire logic [7:0]         wdata,
  input  wire logic               shadow_load,
  output logic [7:0]              rdata,
  output crtc_pkg::crtc_setup_t   setup
);
  import crtc_pkg::*;

  logic [7:0]         reg_file_r   [REG_NUM];
  logic [7:0]         reg_file_nxt [REG_NUM];
  logic [REG_NUM-1:0] written_r, written_nxt;
  logic [7:0]         index_r, index_nxt;
  logic [7:0]         scan_r, scan_nxt;
  logic [7:0]         height_r, height_nxt;
  logic               dirty_r, dirty_nxt;

  logic               idx_ok;
  logic [IDX_W-1:0]   idx_sel;
  logic [7:0]         cur;
  logic               complete;
  logic               go;

  assign idx_ok   = index_r < 8'(REG_NUM);
  assign idx_sel  = index_r[IDX_W-1:0];
  assign cur      = idx_ok ? reg_file_r[idx_sel] : '0;
  assign complete = (&written_r[REG_VSYNC:REG_HTOTAL]) & written_r[REG_MAXSCAN];
  assign go       = (mode == MODE_FRAME) && dirty_r && complete;

  always_comb begin
    rdata = '0;
    if (mode == MODE_READ) begin
      if (addr_bit) begin
        rdata = (index_r >= 8'(REG_READ_LO) && idx_ok) ? cur : RDATA_NONE;
      end else begin
        rdata = index_r;
      end
    end
  end

  always_comb begin
    reg_file_nxt = reg_file_r;
    written_nxt  = written_r;
    index_nxt    = index_r;
    scan_nxt     = scan_r;
    height_nxt   = height_r;
    dirty_nxt    = dirty_r;
    if (step) begin
      case (mode)
        MODE_WRITE: begin
          if (addr_bit) begin
            if (idx_ok) begin
              if (index_r < 8'(REG_DIRTY_LIM) && cur != wdata) dirty_nxt = 1'b1;
              // first write to a scroll register also primes its shadow
              if (index_r == 8'(REG_VADJ) && !written_r[REG_VADJ]) scan_nxt = wdata;
              if (index_r == 8'(REG_MAXSCAN) && !written_r[REG_MAXSCAN]) height_nxt = wdata;
              reg_file_nxt[idx_sel] = wdata;
              written_nxt[idx_sel]  = 1'b1;
            end
          end else begin
            index_nxt = wdata;
          end
        end
        MODE_FRAME: begin
          if (go) dirty_nxt = 1'b0;
        end
        MODE_LINE: begin
          if (shadow_load) begin
            scan_nxt   = reg_file_r[REG_VADJ];
            height_nxt = reg_file_r[REG_MAXSCAN];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < REG_NUM; k++) reg_file_r[k] <= '0;
      written_r <= '0;
      index_r   <= '0;
      dirty_r   <= 1'b0;
    end else begin
      reg_file_r <= reg_file_nxt;
      written_r  <= written_nxt;
      index_r    <= index_nxt;
      dirty_r    <= dirty_nxt;
    end
  end

  // Shadows hold no reset value: they are always written before use
  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    height_r <= height_nxt;
  end

  always_comb begin
    setup.htot_m1       = reg_file_r[REG_HTOTAL];
    setup.hdisp         = reg_file_r[REG_HDISP];
    setup.hsync         = reg_file_r[REG_HSYNC];
    setup.sync_width    = reg_file_r[REG_SYNCW];
    setup.vtot_rows     = reg_file_r[REG_VTOTAL];
    setup.vdisp_rows    = reg_file_r[REG_VDISP];
    setup.vsync_row     = reg_file_r[REG_VSYNC];
    setup.mode_ctl      = reg_file_r[REG_MODE];
    setup.max_scan      = reg_file_r[REG_MAXSCAN];
    setup.scan_shadow   = scan_r;
    setup.height_shadow = height_r;
    setup.dirty         = dirty_r;
    setup.recompute_go  = go;
  end

endmodule
`default_nettype wire

// ===== sv/crtc_timing.sv =====
// Frame timing registers, their recompute logic and per-line status.
`timescale 1ns / 1ps
`default_nettype none
module crtc_timing #(
  parameter int HT_RST = 54,
  parameter int HD_RST = 40,
  parameter int HS_RST = 44,
  parameter int HE_RST = 48,
  parameter int VT_RST = 262,
  parameter int VD_RST = 200,
  parameter int VS_RST = 216,
  parameter int VE_RST = 232
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire crtc_pkg::crtc_mode_t          mode,
  input  wire logic [crtc_pkg::LINE_W-1:0]   line,
  input  wire crtc_pkg::crtc_setup_t         setup,
  output logic                               shadow_load,
  output logic                               line_active,
  output logic                               vsync_out,
  output logic                               hsync_usable,
  output logic [crtc_pkg::LINE_W-1:0]        frame_lines,
  output logic [crtc_pkg::HTOT_W-1:0]        line_chars,
  output logic [7:0]                         disp_chars,
  output logic [7:0]                         hsync_begin,
  output logic [crtc_pkg::HTOT_W-1:0]        hsync_finish
);
  import crtc_pkg::*;

  logic [HTOT_W-1:0] ht_r, ht_nxt;
  logic [7:0]        hd_r, hd_nxt;
  logic [7:0]        hs_r, hs_nxt;
  logic [HTOT_W-1:0] he_r, he_nxt;
  logic [LINE_W-1:0] vt_r, vt_nxt;
  logic [LINE_W-1:0] vd_r, vd_nxt;
  logic [LINE_W-1:0] vs_r, vs_nxt;
  logic [LINE_W-1:0] ve_r, ve_nxt;

  logic [5:0]        h, hb;
  logic [4:0]        vw;
  logic [LINE_W-1:0] vt_calc, vd_calc, vs_calc, ve_calc;
  logic              is_line;
  logic              load;

  assign h  = {1'b0, setup.max_scan[4:0]} + 6'd1;
  assign hb = {1'b0, setup.height_shadow[4:0]} + 6'd1;
  assign vw = (setup.sync_width[7:4] != 4'd0) ? {1'b0, setup.sync_width[7:4]}
                                              : VSYNC_WIDTH_FULL;

  assign vt_calc = ({6'd0, setup.vtot_rows[6:0]} * {7'd0, h}) + {7'd0, hb}
                 + {8'd0, setup.scan_shadow[4:0]};
  assign vd_calc = {6'd0, setup.vdisp_rows[6:0]} * {7'd0, h};
  assign vs_calc = ({6'd0, setup.vsync_row[6:0]} + 13'd1) * {7'd0, h};
  assign ve_calc = vs_calc + {8'd0, vw};

  assign load = step && setup.recompute_go;

  always_comb begin
    ht_nxt = ht_r;
    hd_nxt = hd_r;
    hs_nxt = hs_r;
    he_nxt = he_r;
    vt_nxt = vt_r;
    vd_nxt = vd_r;
    vs_nxt = vs_r;
    ve_nxt = ve_r;
    if (load) begin
      ht_nxt = {1'b0, setup.htot_m1} + 9'd1;
      hd_nxt = setup.hdisp;
      hs_nxt = setup.hsync;
      he_nxt = {1'b0, setup.hsync} + {5'd0, setup.sync_width[3:0]};
      vt_nxt = vt_calc;
      vd_nxt = vd_calc;
      vs_nxt = vs_calc;
      ve_nxt = ve_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ht_r <= HTOT_W'(HT_RST);
      hd_r <= 8'(HD_RST);
      hs_r <= 8'(HS_RST);
      he_r <= HTOT_W'(HE_RST);
      vt_r <= LINE_W'(VT_RST);
      vd_r <= LINE_W'(VD_RST);
      vs_r <= LINE_W'(VS_RST);
      ve_r <= LINE_W'(VE_RST);
    end else begin
      ht_r <= ht_nxt;
      hd_r <= hd_nxt;
      hs_r <= hs_nxt;
      he_r <= he_nxt;
      vt_r <= vt_nxt;
      vd_r <= vd_nxt;
      vs_r <= vs_nxt;
      ve_r <= ve_nxt;
    end
  end

  assign is_line = (mode == MODE_LINE);

  // Zero display height still shows line 0
  assign line_active = is_line && (setup.mode_ctl[5:4] != DISPLAY_OFF)
                     && ((line < vd_r) || (line == '0 && vd_r == '0));
  assign vsync_out   = is_line && (vs_r <= line) && (line < ve_r);
  assign shadow_load = step && is_line && (line == vd_r);

  // Results reflect the state after this item
  assign hsync_usable = ({1'b0, hs_nxt} < he_nxt) && (he_nxt < ht_nxt);
  assign frame_lines  = vt_nxt;
  assign line_chars   = ht_nxt;
  assign disp_chars   = hd_nxt;
  assign hsync_begin  = hs_nxt;
  assign hsync_finish = he_nxt;

endmodule
`default_nettype wire

// ===== sv/crtc_register_timing_core.sv =====
// CRT controller register file with frame timing: top level.
// Use: every input item is one of four kinds given by in_mode: a bus write
// (in_addr_bit 0 sets the register index, 1 writes the indexed register), a
// bus read (index, or registers 12 to 17, else 0xFF), a frame start that
// reloads the timing totals once registers 0 to 7 and 9 are written and
// one of registers 0 to 9 has changed, and a line start that reports
// display-active and vsync for in_line. Each item gives exactly one result
// item on the out_ channel, carrying read data, line status and the current
// timing values. An accepted item sits in the input register and its result
// is then registered in the result register, where out_valid marks it.
// Throughput: one item per cycle while out_ready does not hold the result,
// set by the single pass from the input register to the result register.
// Reset: rst_n low clears registers, index and written flags and loads the
// default timing from the parameters; both channels are empty after reset.
// Stall: while out_ready is low the result is held; the input register still
// takes one more item, after which in_ready stays low until the result goes.
`timescale 1ns / 1ps
`default_nettype none
module crtc_register_timing_core #(
  parameter int CHARS_DEFAULT       = 54,
  parameter int FRAME_LINES_DEFAULT = 262,
  parameter int SCREEN_LINES        = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic        in_addr_bit,
  input  wire logic [7:0]  in_wdata,
  input  wire logic [12:0] in_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_rdata,
  output logic             out_line_active,
  output logic             out_vsync_out,
  output logic             out_hsync_usable,
  output logic [12:0]      out_frame_lines,
  output logic [8:0]       out_line_chars,
  output logic [7:0]       out_disp_chars,
  output logic [7:0]       out_hsync_begin,
  output logic [8:0]       out_hsync_finish
);
  import crtc_pkg::*;

  localparam int LINE_SPAN = 2 ** LINE_W;
  localparam int HT_INIT = (CHARS_DEFAULT > CHARS_MIN) ? CHARS_DEFAULT : CHARS_MIN;
  localparam int HD_INIT = (HT_INIT > HDISP_WIDE) ? HDISP_WIDE : HDISP_NARROW;
  localparam int HS_INIT = HD_INIT + HSYNC_RST_GAP;
  localparam int HE_INIT = HS_INIT + HSYNC_RST_GAP;
  localparam int VT_INIT = FRAME_LINES_DEFAULT % LINE_SPAN;
  localparam int SL_MOD  = SCREEN_LINES % LINE_SPAN;
  localparam int VD_INIT = (SL_MOD > VT_INIT) ? (SL_MOD / 2) : SL_MOD;
  localparam int VS_INIT = (VD_INIT + VSYNC_RST_GAP) % LINE_SPAN;
  localparam int VE_INIT = (VS_INIT + VSYNC_RST_GAP) % LINE_SPAN;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  crtc_mode_t        s1_mode_r;
  logic              s1_addr_r;
  logic [7:0]        s1_wdata_r;
  logic [LINE_W-1:0] s1_line_r;
  logic              advance;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        rdata_r;
  logic              active_r, vsync_r, hok_r;
  logic [LINE_W-1:0] frame_lines_r;
  logic [HTOT_W-1:0] line_chars_r;
  logic [7:0]        disp_chars_r, hsync_begin_r;
  logic [HTOT_W-1:0] hsync_finish_r;

  crtc_setup_t       setup;
  logic [7:0]        rdata;
  logic              shadow_load;
  logic              line_active, vsync, hok;
  logic [LINE_W-1:0] frame_lines;
  logic [HTOT_W-1:0] line_chars;
  logic [7:0]        disp_chars, hsync_begin;
  logic [HTOT_W-1:0] hsync_finish;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (advance)         s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= crtc_mode_t'(in_mode);
      s1_addr_r  <= in_addr_bit;
      s1_wdata_r <= in_wdata;
      s1_line_r  <= in_line;
    end
    if (advance) begin
      rdata_r        <= rdata;
      active_r       <= line_active;
      vsync_r        <= vsync;
      hok_r          <= hok;
      frame_lines_r  <= frame_lines;
      line_chars_r   <= line_chars;
      disp_chars_r   <= disp_chars;
      hsync_begin_r  <= hsync_begin;
      hsync_finish_r <= hsync_finish;
    end
  end

  crtc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .mode        (s1_mode_r),
    .addr_bit    (s1_addr_r),
    .wdata       (s1_wdata_r),
    .shadow_load (shadow_load),
    .rdata       (rdata),
    .setup       (setup)
  );

  crtc_timing #(
    .HT_RST (HT_INIT),
    .HD_RST (HD_INIT),
    .HS_RST (HS_INIT),
    .HE_RST (HE_INIT),
    .VT_RST (VT_INIT),
    .VD_RST (VD_INIT),
    .VS_RST (VS_INIT),
    .VE_RST (VE_INIT)
  ) u_timing (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .mode         (s1_mode_r),
    .line         (s1_line_r),
    .setup        (setup),
    .shadow_load  (shadow_load),
    .line_active  (line_active),
    .vsync_out    (vsync),
    .hsync_usable (hok),
    .frame_lines  (frame_lines),
    .line_chars   (line_chars),
    .disp_chars   (disp_chars),
    .hsync_begin  (hsync_begin),
    .hsync_finish (hsync_finish)
  );

  assign out_valid        = out_valid_r;
  assign out_rdata        = rdata_r;
  assign out_line_active  = active_r;
  assign out_vsync_out    = vsync_r;
  assign out_hsync_usable = hok_r;
  assign out_frame_lines  = frame_lines_r;
  assign out_line_chars   = line_chars_r;
  assign out_disp_chars   = disp_chars_r;
  assign out_hsync_begin  = hsync_begin_r;
  assign out_hsync_finish = hsync_finish_r;

  a_line_flags_only_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_mode_r != MODE_LINE) |=> (!out_line_active && !out_vsync_out))
    else $error("line status set on an item that is not a line start");

  a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_mode_r != MODE_READ) |=> (out_rdata == 8'd0))
    else $error("read data set on an item that is not a bus read");

  a_recompute_clears_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && setup.recompute_go) |=> !setup.dirty)
    else $error("timing change flag survived a recompute");

  a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_mode_r)
                                  && $stable(s1_line_r) && $stable(s1_wdata_r)))
    else $error("held input item changed while waiting");

endmodule
`default_nettype wire
